FILE: design/tsc_pkg.sv
// Shared types and constants for the tick scheduler with command line.
// Holds the beat structs of both channels and the control structs between modules.
// No dependencies.
package tsc_pkg;

	// Operation codes of the command channel
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_SET_SEC = 2'd2;
	localparam logic [1:0] OP_SET_DAY = 2'd3;

	// Result kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CHAR = 1'b1;

	// Register indexes on the configuration port
	localparam logic REG_ENABLE     = 1'b0;
	localparam logic REG_IDLE_LIMIT = 1'b1;

	// Register reset values
	localparam logic       ENABLE_RESET     = 1'b1;
	localparam logic [7:0] IDLE_LIMIT_RESET = 8'd180;

	// Time keeping constants
	localparam logic [16:0] DAY_SECONDS     = 17'd86400;
	localparam logic [16:0] LAST_SECOND     = 17'd86399;
	localparam logic [10:0] DAY_CYCLE       = 11'd1461;
	localparam logic [16:0] PERIOD_SECONDS  = 17'd450;
	localparam logic [8:0]  LAST_PHASE      = 9'd449;
	localparam logic [16:0] MEASURE_SECONDS = 17'd15;
	localparam logic [3:0]  LAST_MEASURE    = 4'd14;

	// Actuator start offsets within one period
	localparam logic [8:0] ACT0_OFFSET = 9'd0;
	localparam logic [8:0] ACT1_OFFSET = 9'd110;
	localparam logic [8:0] ACT2_OFFSET = 9'd220;
	localparam logic [8:0] ACT3_OFFSET = 9'd330;

	// Special bytes
	localparam logic [7:0] BYTE_BS      = 8'd8;
	localparam logic [7:0] BYTE_CR      = 8'd13;
	localparam logic [7:0] BYTE_PR_LOW  = 8'd32;
	localparam logic [7:0] BYTE_PR_HIGH = 8'd126;

	// Default line length
	localparam int LINE_CHARS_DEF = 16;

	typedef struct packed {
		logic [1:0]  op;
		logic [16:0] value;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [16:0] seconds;
		logic [10:0] day;
		logic        measure_now;
		logic        actuator_start;
		logic [1:0]  actuator_index;
		logic        serial_reset;
		logic [6:0]  line_char;
		logic        line_last;
	} res_t;

	// Top to time keeper
	typedef struct packed {
		logic        tick;
		logic        set_sec;
		logic        set_day;
		logic [16:0] value;
	} time_ctl_t;

	// Time keeper to top: values after a tick, and busy
	typedef struct packed {
		logic        busy;
		logic [16:0] sod;
		logic [10:0] day;
		logic [8:0]  phase;
		logic [3:0]  meas_phase;
	} time_sts_t;

	// Top to line buffer
	typedef struct packed {
		logic       byte_go;
		logic [7:0] byte_val;
		logic       clear;
		logic       chr_take;
	} line_ctl_t;

	// Line buffer to top
	typedef struct packed {
		logic       busy;
		logic       stored;
		logic       chr_valid;
		logic [6:0] chr;
		logic       last;
	} line_sts_t;

endpackage

FILE: design/tick_scheduler_with_command_line.sv
// Top level of the tick scheduler with command line: handshakes, registers,
// idle counter, schedule decode and the result register.
// Depends on tsc_pkg, tsc_time and tsc_line.
//
//  port group    dir  beat contents
//  cmd_*         in   op, value (tick, received byte, set seconds, set day)
//  res_*         out  tick report or one command line character
//  p* (APB)      cfg  enable_schedule at 0x0, idle_limit at 0x4
//
// A carriage return holds off commands while the line is read out: each
// character passes a memory read state, then a hold state that waits for
// the result side. A set of seconds holds off commands while the remainder
// unit reloads the schedule phases. Reset clears time, day, idle count and
// line length; stored characters are not cleared. A result waiting on
// res_ready holds off the next command.
module tick_scheduler_with_command_line #(
	parameter int LINE_CHARS = tsc_pkg::LINE_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  tsc_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output tsc_pkg::res_t  res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic       en_q;
	logic [7:0] limit_q;
	logic [7:0] idle_q;
	logic       res_valid_q;
	tsc_pkg::res_t res_q;

	tsc_pkg::time_ctl_t t_ctl;
	tsc_pkg::time_sts_t t_sts;
	tsc_pkg::line_ctl_t l_ctl;
	tsc_pkg::line_sts_t l_sts;

	logic       cmd_fire;
	logic       tick_fire;
	logic       res_free;
	logic       chr_take;
	logic [7:0] idle_inc;
	logic       sreset_now;
	logic       meas;
	logic       act;
	logic [1:0] act_idx;

	// Current day from the next-tick view: undo a day step at midnight
	function automatic logic [10:0] u_day_now(input tsc_pkg::time_sts_t s);
		logic [10:0] d;
		begin
			d = s.day;
			if (s.sod == 17'd0) begin
				d = (s.day == 11'd1) ? tsc_pkg::DAY_CYCLE : s.day - 11'd1;
			end
			return d;
		end
	endfunction

	assign pready    = 1'b1;
	assign res_free  = !res_valid_q || res_ready;
	assign cmd_ready = !t_sts.busy && !l_sts.busy && res_free;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign tick_fire = cmd_fire && (cmd.op == tsc_pkg::OP_TICK);
	assign chr_take  = l_sts.chr_valid && res_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Idle counter step and serial reset decision
	assign idle_inc   = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
	assign sreset_now = (idle_inc > limit_q);

	always_comb begin
		t_ctl.tick    = tick_fire;
		t_ctl.set_sec = cmd_fire && (cmd.op == tsc_pkg::OP_SET_SEC);
		t_ctl.set_day = cmd_fire && (cmd.op == tsc_pkg::OP_SET_DAY);
		t_ctl.value   = cmd.value;
		l_ctl.byte_go  = cmd_fire && (cmd.op == tsc_pkg::OP_BYTE);
		l_ctl.byte_val = cmd.value[7:0];
		l_ctl.clear    = tick_fire && sreset_now;
		l_ctl.chr_take = chr_take;
	end

	tsc_time u_time (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (t_ctl),
		.sts    (t_sts)
	);

	tsc_line #(
		.LINE_CHARS (LINE_CHARS)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (l_ctl),
		.sts    (l_sts)
	);

	// Decode the schedule from the phases after the tick
	always_comb begin
		act     = 1'b0;
		act_idx = 2'd0;
		meas    = en_q && (t_sts.meas_phase == 4'd0);
		if (en_q) begin
			case (t_sts.phase)
				tsc_pkg::ACT0_OFFSET: begin
					act     = 1'b1;
					act_idx = 2'd0;
				end
				tsc_pkg::ACT1_OFFSET: begin
					act     = 1'b1;
					act_idx = 2'd1;
				end
				tsc_pkg::ACT2_OFFSET: begin
					act     = 1'b1;
					act_idx = 2'd2;
				end
				tsc_pkg::ACT3_OFFSET: begin
					act     = 1'b1;
					act_idx = 2'd3;
				end
				default: begin
					act     = 1'b0;
					act_idx = 2'd0;
				end
			endcase
		end
	end

	// Register read mux
	always_comb begin
		case (paddr[2])
			tsc_pkg::REG_ENABLE:     prdata = {31'd0, en_q};
			tsc_pkg::REG_IDLE_LIMIT: prdata = {24'd0, limit_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// Configuration writes, idle counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= tsc_pkg::ENABLE_RESET;
			limit_q     <= tsc_pkg::IDLE_LIMIT_RESET;
			idle_q      <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == tsc_pkg::REG_ENABLE) begin
					en_q <= pwdata[0];
				end else begin
					limit_q <= pwdata[7:0];
				end
			end
			if (tick_fire) begin
				idle_q <= sreset_now ? 8'd0 : idle_inc;
			end else if (l_sts.stored) begin
				idle_q <= 8'd0;
			end
			if (tick_fire || chr_take) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (tick_fire) begin
			res_q.kind           <= tsc_pkg::KIND_TICK;
			res_q.seconds        <= t_sts.sod;
			res_q.day            <= t_sts.day;
			res_q.measure_now    <= meas;
			res_q.actuator_start <= act;
			res_q.actuator_index <= act_idx;
			res_q.serial_reset   <= sreset_now;
			res_q.line_char      <= 7'd0;
			res_q.line_last      <= 1'b0;
		end else if (chr_take) begin
			res_q.kind           <= tsc_pkg::KIND_CHAR;
			res_q.seconds        <= t_sts.sod - (t_sts.sod == 17'd0 ? 17'd0 : 17'd1)
				+ (t_sts.sod == 17'd0 ? tsc_pkg::LAST_SECOND : 17'd0);
			res_q.day            <= u_day_now(t_sts);
			res_q.measure_now    <= 1'b0;
			res_q.actuator_start <= 1'b0;
			res_q.actuator_index <= 2'd0;
			res_q.serial_reset   <= 1'b0;
			res_q.line_char      <= l_sts.chr;
			res_q.line_last      <= l_sts.last;
		end
	end

endmodule

FILE: design/tsc_time.sv
// Time keeper: second of day, day number and the two schedule phase counters.
// A set of seconds reloads the phases through a reciprocal-multiply remainder unit.
// Depends on tsc_pkg.
module tsc_time (
	input  logic                clk,
	input  logic                arst_n,
	input  tsc_pkg::time_ctl_t  ctl,
	output tsc_pkg::time_sts_t  sts
);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_QUO  = 2'd1;
	localparam logic [1:0] T_REM  = 2'd2;

	// Reciprocals of 450 and 15, exact for any 17-bit second of day
	localparam logic [17:0] RECIP_450 = 18'd149131;
	localparam logic [17:0] RECIP_15  = 18'd139811;

	logic [1:0]  state_q;
	logic [16:0] red_q;
	logic [8:0]  quo450_q;
	logic [13:0] quo15_q;
	logic [16:0] sod_q;
	logic [10:0] day_q;
	logic [8:0]  ph_q;
	logic [3:0]  mph_q;

	logic [16:0] sod_n;
	logic [10:0] day_n;
	logic [8:0]  ph_n;
	logic [3:0]  mph_n;
	logic [34:0] prod450;
	logic [34:0] prod15;
	logic [16:0] rem450;
	logic [16:0] rem15;

	// Values after one tick
	always_comb begin
		sod_n = (sod_q == tsc_pkg::LAST_SECOND) ? 17'd0 : sod_q + 17'd1;
		day_n = day_q;
		if (sod_q == tsc_pkg::LAST_SECOND) begin
			day_n = (day_q == tsc_pkg::DAY_CYCLE) ? 11'd1 : day_q + 11'd1;
		end
		ph_n  = (ph_q == tsc_pkg::LAST_PHASE) ? 9'd0 : ph_q + 9'd1;
		mph_n = (mph_q == tsc_pkg::LAST_MEASURE) ? 4'd0 : mph_q + 4'd1;
	end

	// Quotients by reciprocal multiply, remainders by multiply-back and subtract
	always_comb begin
		prod450 = 35'(red_q) * 35'(RECIP_450);
		prod15  = 35'(red_q) * 35'(RECIP_15);
		rem450  = red_q - 17'(quo450_q) * tsc_pkg::PERIOD_SECONDS;
		rem15   = red_q - 17'(quo15_q) * tsc_pkg::MEASURE_SECONDS;
	end

	assign sts.busy       = (state_q != T_IDLE);
	assign sts.sod        = sod_n;
	assign sts.day        = day_n;
	assign sts.phase      = ph_n;
	assign sts.meas_phase = mph_n;

	// Advance time, take set requests, run the phase reload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			sod_q   <= 17'd0;
			day_q   <= 11'd1;
			ph_q    <= 9'd0;
			mph_q   <= 4'd0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (ctl.tick) begin
						sod_q <= sod_n;
						day_q <= day_n;
						ph_q  <= ph_n;
						mph_q <= mph_n;
					end else if (ctl.set_sec && ctl.value < tsc_pkg::DAY_SECONDS) begin
						sod_q   <= ctl.value;
						state_q <= T_QUO;
					end else if (ctl.set_day && ctl.value >= 17'd1
							&& ctl.value <= 17'(tsc_pkg::DAY_CYCLE)) begin
						day_q <= ctl.value[10:0];
					end
				end
				T_QUO: begin
					state_q <= T_REM;
				end
				T_REM: begin
					ph_q    <= rem450[8:0];
					mph_q   <= rem15[3:0];
					state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// Remainder working registers: hold the value, register the quotients
	always_ff @(posedge clk) begin
		if (state_q == T_IDLE) begin
			red_q <= ctl.value;
		end
		quo450_q <= prod450[34:26];
		quo15_q  <= prod15[34:21];
	end

endmodule

FILE: design/tsc_line.sv
// Command line buffer: character memory, fill length and the readout sequencer.
// Readout reads one entry per character through the registered memory port.
// Depends on tsc_pkg.
module tsc_line #(
	parameter int LINE_CHARS = tsc_pkg::LINE_CHARS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsc_pkg::line_ctl_t  ctl,
	output tsc_pkg::line_sts_t  sts
);

	localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
	localparam int LW = $clog2(LINE_CHARS + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(LINE_CHARS);

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_READ = 2'd1;
	localparam logic [1:0] L_HOLD = 2'd2;

	logic [6:0]    mem [LINE_CHARS];
	logic [6:0]    rd_data_q;
	logic [1:0]    state_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] idx_q;

	logic is_bs;
	logic is_cr;
	logic is_pr;
	logic store;
	logic last;

	// Decode the received byte
	always_comb begin
		is_bs = (ctl.byte_val == tsc_pkg::BYTE_BS);
		is_cr = (ctl.byte_val == tsc_pkg::BYTE_CR);
		is_pr = (ctl.byte_val >= tsc_pkg::BYTE_PR_LOW) && (ctl.byte_val <= tsc_pkg::BYTE_PR_HIGH);
		store = ctl.byte_go && is_pr && (len_q < LEN_MAX);
		last  = ((idx_q + LW'(1)) == len_q);
	end

	assign sts.busy      = (state_q != L_IDLE);
	assign sts.stored    = store;
	assign sts.chr_valid = (state_q == L_HOLD);
	assign sts.chr       = rd_data_q;
	assign sts.last      = last;

	// Character memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store) begin
			mem[len_q[AW-1:0]] <= ctl.byte_val[6:0];
		end
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	// Track length and walk the line on carriage return
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			len_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (ctl.clear) begin
						len_q <= '0;
					end else if (ctl.byte_go) begin
						if (is_bs) begin
							if (len_q != '0) begin
								len_q <= len_q - LW'(1);
							end
						end else if (is_cr) begin
							if (len_q != '0) begin
								idx_q   <= '0;
								state_q <= L_READ;
							end
						end else if (store) begin
							len_q <= len_q + LW'(1);
						end
					end
				end
				L_READ: begin
					state_q <= L_HOLD;
				end
				L_HOLD: begin
					if (ctl.chr_take) begin
						if (last) begin
							len_q   <= '0;
							state_q <= L_IDLE;
						end else begin
							idx_q   <= idx_q + LW'(1);
							state_q <= L_READ;
						end
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/tsc_result_checker.sv
// Scoreboard for the tick scheduler with command line: tracks register writes,
// predicts the result beats that accepted command beats produce and compares them in order.
// Depends on tsc_pkg.
module tsc_result_checker import tsc_pkg::*; #(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int unsigned mismatches,
	output int unsigned backlog
);

	localparam logic [7:0] IDLE_MAX = 8'd255;

	// Shadow registers and time / line state
	logic        sched_on;
	logic [7:0]  idle_lim;
	logic [16:0] sec;
	logic [10:0] day;
	logic [7:0]  idle;
	int unsigned line_len;
	logic [6:0]  line_buf [LINE_CHARS];
	res_t        due_beats [$];
	res_t        want;

	// Advance the shadow state by one command and queue the beats it produces
	task automatic predict_cmd(input cmd_t c);
		res_t        r;
		logic [7:0]  b;
		logic [8:0]  ph;
		int unsigned i;
		r = '0;
		case (c.op)
			OP_TICK: begin
				if (sec == LAST_SECOND) begin
					sec = '0;
					day = (day == DAY_CYCLE) ? 11'd1 : day + 11'd1;
				end else begin
					sec = sec + 17'd1;
				end
				if (idle != IDLE_MAX)
					idle = idle + 8'd1;
				r.kind = KIND_TICK;
				if (idle > idle_lim) begin
					r.serial_reset = 1'b1;
					idle = '0;
					line_len = 0;
				end
				if (sched_on) begin
					ph = 9'(sec % PERIOD_SECONDS);
					r.measure_now = (sec % MEASURE_SECONDS) == 17'd0;
					case (ph)
						ACT0_OFFSET: begin
							r.actuator_start = 1'b1;
							r.actuator_index = 2'd0;
							r.measure_now = 1'b1;
						end
						ACT1_OFFSET: begin
							r.actuator_start = 1'b1;
							r.actuator_index = 2'd1;
						end
						ACT2_OFFSET: begin
							r.actuator_start = 1'b1;
							r.actuator_index = 2'd2;
						end
						ACT3_OFFSET: begin
							r.actuator_start = 1'b1;
							r.actuator_index = 2'd3;
						end
						default: ;
					endcase
				end
				r.seconds = sec;
				r.day = day;
				due_beats.push_back(r);
			end
			OP_BYTE: begin
				b = c.value[7:0];
				if (b == BYTE_BS) begin
					if (line_len > 0)
						line_len = line_len - 1;
				end else if (b == BYTE_CR) begin
					// emit the whole line, one character per beat
					for (i = 0; i < line_len; i++) begin
						r = '0;
						r.kind = KIND_CHAR;
						r.seconds = sec;
						r.day = day;
						r.line_char = line_buf[i];
						r.line_last = (i + 1 == line_len);
						due_beats.push_back(r);
					end
					line_len = 0;
				end else if (b >= BYTE_PR_LOW && b <= BYTE_PR_HIGH && line_len < LINE_CHARS) begin
					line_buf[line_len] = b[6:0];
					line_len = line_len + 1;
					idle = '0;
				end
			end
			OP_SET_SEC: begin
				if (c.value < DAY_SECONDS)
					sec = c.value;
			end
			OP_SET_DAY: begin
				if (c.value != 17'd0 && c.value <= 17'(DAY_CYCLE))
					day = c.value[10:0];
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input longint unsigned exp_v,
			input longint unsigned got_v);
		if (exp_v != got_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
		end
	endtask

	// Track registers, check result beats, then predict from command beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_on = ENABLE_RESET;
			idle_lim = IDLE_LIMIT_RESET;
			sec = '0;
			day = 11'd1;
			idle = '0;
			line_len = 0;
			due_beats.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_IDLE_LIMIT)
					idle_lim = pwdata[7:0];
				else
					sched_on = pwdata[0];
			end
			if (res_valid && res_ready) begin
				if (due_beats.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none expected, actual %h", $time, res);
				end else begin
					want = due_beats.pop_front();
					check_field("kind", want.kind, res.kind);
					check_field("seconds", want.seconds, res.seconds);
					check_field("day", want.day, res.day);
					check_field("measure_now", want.measure_now, res.measure_now);
					check_field("actuator_start", want.actuator_start, res.actuator_start);
					check_field("actuator_index", want.actuator_index, res.actuator_index);
					check_field("serial_reset", want.serial_reset, res.serial_reset);
					check_field("line_char", want.line_char, res.line_char);
					check_field("line_last", want.line_last, res.line_last);
				end
			end
			if (cmd_valid && cmd_ready)
				predict_cmd(cmd);
		end
		backlog = due_beats.size();
	end

endmodule

FILE: tb/tb_tick_scheduler_with_command_line.sv
// Testbench top for the tick scheduler with command line: clock, reset, command,
// result-ready and register stimulus, watchdog and verdict.
// Depends on tsc_pkg, tick_scheduler_with_command_line and tsc_result_checker.
module tb_tick_scheduler_with_command_line;
	import tsc_pkg::*;

	localparam int unsigned STALL_LIMIT   = 3000;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam logic [7:0]  BYTE_LF       = 8'd10;
	localparam logic [7:0]  BYTE_DEL      = 8'd127;
	localparam logic [7:0]  BYTE_US       = 8'd31;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned mismatches;
	int unsigned backlog;
	int unsigned quiet_cycles;
	int unsigned items;
	bit          tx_calm;
	bit          rx_calm;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tick_scheduler_with_command_line i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	tsc_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.backlog    (backlog)
	);

	// Draw a wait; flip now and then between calm stretches and gappy ones
	function automatic int unsigned draw_gap(inout bit calm);
		if ($urandom_range(0, 23) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic logic [16:0] any_value();
		return 17'($urandom);
	endfunction

	// Send one command beat and hold it until accepted
	task automatic send(input logic [1:0] op, input logic [16:0] value);
		int unsigned gap;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= {op, value};
		do @(posedge clk); while (!cmd_ready);
		items++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send(OP_BYTE, {9'($urandom), b});
	endtask

	// Drop valid, drain all expected beats, then let the block go quiet
	task automatic settle();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (backlog != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic en, input logic [7:0] lim);
		settle();
		write_reg(REG_ENABLE, {31'($urandom), en});
		write_reg(REG_IDLE_LIMIT, {24'($urandom), lim});
	endtask

	// Type a printable line with occasional backspaces and ticks, then end it
	task automatic type_line();
		int unsigned len;
		int unsigned i;
		len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_byte(BYTE_BS);
			send_byte(8'($urandom_range(BYTE_PR_LOW, BYTE_PR_HIGH)));
			if ($urandom_range(0, 7) == 0)
				send(OP_TICK, any_value());
		end
		send_byte(BYTE_CR);
	endtask

	// Jump close to a day wrap, an actuator offset or a measure point, or to any second, then tick
	task automatic jump_and_tick();
		int target;
		int off;
		case ($urandom_range(0, 3))
			0: target = int'(LAST_SECOND) - int'($urandom_range(0, 3));
			1: begin
				case ($urandom_range(0, 3))
					0: off = int'(ACT0_OFFSET);
					1: off = int'(ACT1_OFFSET);
					2: off = int'(ACT2_OFFSET);
					default: off = int'(ACT3_OFFSET);
				endcase
				target = int'(PERIOD_SECONDS) * int'($urandom_range(0, 191)) + off
					- int'($urandom_range(1, 3));
				if (target < 0)
					target = 0;
			end
			2: target = int'(MEASURE_SECONDS) * int'($urandom_range(0, 5759))
				- int'($urandom_range(0, 2));
			default: target = int'($urandom_range(0, LAST_SECOND));
		endcase
		if (target < 0)
			target = 0;
		send(OP_SET_SEC, 17'(target));
		repeat ($urandom_range(1, 6)) send(OP_TICK, any_value());
	endtask

	task automatic random_phase(input int unsigned quota);
		int unsigned stop;
		stop = items + quota;
		while (items < stop) begin
			case ($urandom_range(0, 9))
				0, 1, 2: repeat ($urandom_range(1, 8)) send(OP_TICK, any_value());
				3, 4, 5: type_line();
				6: jump_and_tick();
				7: begin
					if ($urandom_range(0, 3) == 0)
						send(OP_SET_DAY, any_value());
					else
						send(OP_SET_DAY, 17'($urandom_range(1, DAY_CYCLE)));
				end
				8: send(2'($urandom), any_value());
				default: send_byte(8'($urandom));
			endcase
		end
	endtask

	// Edge cases: wraps, range checks, actuator offsets and line editing
	task automatic directed();
		send(OP_TICK, 17'h1FFFF);
		send(OP_SET_SEC, LAST_SECOND);
		send(OP_TICK, '0);
		send(OP_SET_DAY, 17'(DAY_CYCLE));
		send(OP_SET_SEC, LAST_SECOND);
		send(OP_TICK, '0);
		send(OP_SET_SEC, DAY_SECONDS);
		send(OP_SET_SEC, 17'h1FFFF);
		send(OP_SET_DAY, '0);
		send(OP_SET_DAY, 17'(DAY_CYCLE) + 17'd1);
		send(OP_SET_SEC, 17'(ACT1_OFFSET) - 17'd1);
		send(OP_TICK, '0);
		send(OP_SET_SEC, 17'(ACT2_OFFSET) - 17'd1);
		send(OP_TICK, '0);
		send(OP_SET_SEC, 17'(ACT3_OFFSET) - 17'd1);
		send(OP_TICK, '0);
		send_byte(BYTE_BS);
		send_byte(BYTE_PR_LOW);
		send_byte(BYTE_PR_HIGH);
		send_byte(BYTE_DEL);
		send_byte(BYTE_US);
		send_byte(BYTE_LF);
		send_byte(8'hFF);
		send(OP_BYTE, {9'h1FF, 8'h78});
		send_byte(BYTE_BS);
		send_byte(BYTE_CR);
		send_byte(BYTE_CR);
	endtask

	// Result side: stall a random number of cycles before taking each beat
	initial begin
		int unsigned stall;
		res_ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = draw_gap(rx_calm);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Main stimulus
	initial begin
		quiet_cycles = 0;
		items = 0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		random_phase(20);
		configure(1'b0, 8'd1);
		random_phase(25);
		configure(1'b1, 8'd0);
		random_phase(20);
		configure(1'b1, 8'd1);
		random_phase(20);
		// hold the idle counter at its ceiling with no serial reset
		configure(1'b1, 8'd255);
		repeat (262) send(OP_TICK, any_value());
		configure(1'b0, IDLE_LIMIT_RESET);
		send(OP_TICK, any_value());
		random_phase(20);
		configure(1'b1, 8'($urandom_range(2, 254)));
		random_phase(25);
		configure(ENABLE_RESET, IDLE_LIMIT_RESET);
		random_phase(20);

		settle();
		if (mismatches == 0 && backlog == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
